[rtl/core/rlfnv_pkg.sv]
// rlfnv_pkg: shared constants, types and helper functions of the read-line
// FNV-1a 64 checksum core. No dependencies; imported by rlfnv_stats and read_line_fnv_checksum_core.
`default_nettype none

package rlfnv_pkg;

  localparam int HASH_W       = 64;
  localparam int ROW_W        = 32;
  localparam int BASE_W       = 48;
  localparam int LEN_W        = 17;
  localparam int QOFF_W       = 6;
  localparam int DEF_MAX_LINE = 512;

  localparam logic [HASH_W-1:0] FNV_BASIS    = 64'hcbf29ce484222325;
  // prime is 2^40 + 0x1b3
  localparam int                FNV_SHIFT    = 40;
  localparam logic [8:0]        FNV_PRIME_LO = 9'h1b3;

  localparam logic [LEN_W-1:0]  LEN_MAX   = '1;
  localparam logic [ROW_W-1:0]  ROWS_MAX  = '1;
  localparam logic [BASE_W-1:0] BASES_MAX = '1;

  localparam logic [7:0] CH_HASH = 8'h23;  // '#'
  localparam logic [7:0] CH_BANG = 8'h21;  // '!'
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UT   = 8'h54;
  localparam logic [7:0] CH_UC   = 8'h43;
  localparam logic [7:0] CH_UG   = 8'h47;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LT   = 8'h74;
  localparam logic [7:0] CH_LC   = 8'h63;
  localparam logic [7:0] CH_LG   = 8'h67;

  typedef struct packed {
    logic              start;
    logic              mate;
    logic              qual;
    logic [HASH_W-1:0] hash;
    logic [LEN_W-1:0]  len;
  } stats_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] checksum;
    logic [ROW_W-1:0]  rows;
    logic [BASE_W-1:0] bases;
  } stats_res_t;

  // one FNV-1a step: xor, then multiply by 2^40 + 0x1b3 (mod 2^64)
  function automatic logic [HASH_W-1:0] fnv_byte(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] c);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, c};
    return (x << FNV_SHIFT) + (x * {{(HASH_W-9){1'b0}}, FNV_PRIME_LO});
  endfunction

  function automatic logic [7:0] complement(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      CH_UA:   r = CH_UT;
      CH_UT:   r = CH_UA;
      CH_UC:   r = CH_UG;
      CH_UG:   r = CH_UC;
      CH_LA:   r = CH_LT;
      CH_LT:   r = CH_LA;
      CH_LC:   r = CH_LG;
      CH_LG:   r = CH_LC;
      default: r = c;
    endcase
    return r;
  endfunction

  // '#' -> '!', then add the signed offset, wrapping at 8 bits
  function automatic logic [7:0] norm_quality(input logic [7:0] c,
                                              input logic [QOFF_W-1:0] off);
    logic [7:0] b;
    b = (c == CH_HASH) ? CH_BANG : c;
    return b + {{(8-QOFF_W){off[QOFF_W-1]}}, off};
  endfunction

endpackage

`default_nettype wire

[rtl/core/rlfnv_line_buf.sv]
// rlfnv_line_buf: character store for reversed lines, one write port and one
// read port with registered read data. No package dependency.
`default_nettype none

module rlfnv_line_buf #(
  parameter int MAX_LINE = 512
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [$clog2(MAX_LINE)-1:0]   wr_addr,
  input  wire [7:0]                    wr_data,
  input  wire                          rd_en,
  input  wire [$clog2(MAX_LINE)-1:0]   rd_addr,
  output logic [7:0]                   rd_data
);

  logic [7:0] mem [MAX_LINE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/rlfnv_stats.sv]
// rlfnv_stats: XOR accumulators and per-mate row/base counters held in small
// memories, updated by a read-modify-write (registered read stage, then write back). Uses rlfnv_pkg.
`default_nettype none

module rlfnv_stats (
  input  wire                     clk,
  input  wire                     rst,
  input  wire rlfnv_pkg::stats_req_t req,
  output rlfnv_pkg::stats_res_t   res
);

  import rlfnv_pkg::*;

  logic [HASH_W-1:0] acc_mem   [4];
  logic [ROW_W-1:0]  rows_mem  [2];
  logic [BASE_W-1:0] bases_mem [2];
  logic [3:0]        acc_vld;
  logic [1:0]        cnt_vld;

  logic              pend;
  logic              p_mate;
  logic              p_qual;
  logic [HASH_W-1:0] p_hash;
  logic [LEN_W-1:0]  p_len;
  logic [HASH_W-1:0] acc_rd;
  logic [ROW_W-1:0]  rows_rd;
  logic [BASE_W-1:0] bases_rd;

  logic [1:0]        rd_idx;
  logic [1:0]        p_idx;
  logic [HASH_W-1:0] acc_new;
  logic [ROW_W-1:0]  rows_new;
  logic [BASE_W:0]   bsum;
  logic [BASE_W-1:0] bases_new;

  assign rd_idx = {req.mate, req.qual};
  assign p_idx  = {p_mate, p_qual};

  // control and valid bits; never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      acc_vld <= '0;
      cnt_vld <= '0;
    end else begin
      pend <= req.start;
      if (pend) begin
        acc_vld[p_idx] <= 1'b1;
        if (!p_qual) begin
          cnt_vld[p_mate] <= 1'b1;
        end
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (req.start) begin
      p_mate   <= req.mate;
      p_qual   <= req.qual;
      p_hash   <= req.hash;
      p_len    <= req.len;
      acc_rd   <= acc_vld[rd_idx] ? acc_mem[rd_idx] : '0;
      rows_rd  <= cnt_vld[req.mate] ? rows_mem[req.mate] : '0;
      bases_rd <= cnt_vld[req.mate] ? bases_mem[req.mate] : '0;
    end
  end

  // modify
  always_comb begin
    acc_new  = acc_rd ^ p_hash;
    rows_new = rows_rd;
    bsum     = {1'b0, bases_rd} + {{(BASE_W+1-LEN_W){1'b0}}, p_len};
    bases_new = bases_rd;
    if (!p_qual) begin
      if (rows_rd != ROWS_MAX) begin
        rows_new = rows_rd + ROW_W'(1);
      end
      bases_new = bsum[BASE_W] ? BASES_MAX : bsum[BASE_W-1:0];
    end
  end

  // write back
  always_ff @(posedge clk) begin
    if (pend) begin
      acc_mem[p_idx] <= acc_new;
      if (!p_qual) begin
        rows_mem[p_mate]  <= rows_new;
        bases_mem[p_mate] <= bases_new;
      end
    end
  end

  assign res.done     = pend;
  assign res.checksum = acc_new;
  assign res.rows     = rows_new;
  assign res.bases    = bases_new;

endmodule

`default_nettype wire

[rtl/core/read_line_fnv_checksum_core.sv]
// read_line_fnv_checksum_core: top level. Line FNV-1a 64 hashing, reversed
// line replay and result register. Uses rlfnv_pkg, rlfnv_line_buf, rlfnv_stats.
`default_nettype none

// Channel   Dir  Handshake             Payload
// in        in   in_valid/in_ready     ch, has_char, mate, is_quality, reversed, last
// out       out  out_valid/out_ready   line_hash, out_mate, out_is_quality, checksum,
//                                      row_count, base_count, overflow
// cfg       in   cfg_valid/cfg_ready   quality_offset (always ready)
//
// Forward line: one request per cycle; hash step (xor, prime as shift plus
// 9-bit product) on the accepting edge. Reversed line: one request per cycle
// into the line store, then replay from the store, last char first. Line end:
// input held off in S_STATS while the previous result is untaken and in S_WAIT
// for the stats read-modify-write; the result then waits in the output register
// as the next line's chars are taken. Sync reset; store not cleared.

module read_line_fnv_checksum_core #(
  parameter int MAX_LINE = rlfnv_pkg::DEF_MAX_LINE
) (
  input  wire                               clk,
  input  wire                               rst,
  // config
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [rlfnv_pkg::QOFF_W-1:0]      quality_offset,
  // input requests
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [7:0]                        ch,
  input  wire                               has_char,
  input  wire                               mate,
  input  wire                               is_quality,
  input  wire                               reversed,
  input  wire                               last,
  // results
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [rlfnv_pkg::HASH_W-1:0]      line_hash,
  output logic                              out_mate,
  output logic                              out_is_quality,
  output logic [rlfnv_pkg::HASH_W-1:0]      checksum,
  output logic [rlfnv_pkg::ROW_W-1:0]       row_count,
  output logic [rlfnv_pkg::BASE_W-1:0]      base_count,
  output logic                              overflow
);

  import rlfnv_pkg::*;

  localparam int AW = $clog2(MAX_LINE);
  localparam logic [LEN_W-1:0] STORE_MAX = LEN_W'(MAX_LINE);

  typedef enum logic [1:0] {
    S_IN,      // taking chars of the open line
    S_REPLAY,  // hashing a reversed line from the store, last char first
    S_STATS,   // waiting for a free result slot
    S_WAIT     // stats read-modify-write in flight
  } state_t;

  state_t            state;
  logic [QOFF_W-1:0] qoff;
  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] hash_next;
  logic [LEN_W-1:0]  line_len;
  logic [LEN_W-1:0]  len_next;
  logic              ov;
  logic              line_open;
  logic              lat_mate;
  logic              lat_qual;
  logic              lat_rev;
  logic [LEN_W-1:0]  rep_cnt;
  logic [LEN_W-1:0]  rep_cnt_m1;
  logic              rep_pend;

  logic              in_acc;
  logic              eff_mate;
  logic              eff_qual;
  logic              eff_rev;
  logic [7:0]        c_in;
  logic [7:0]        c_rep;
  logic              store_wr;
  logic              ov_set;
  logic              rep_issue;
  logic [7:0]        buf_rd_data;
  logic              slot_free;
  logic              line_done;
  stats_req_t        sreq;
  stats_res_t        sres;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IN);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign line_done = (state == S_WAIT) && sres.done;

  // flags come from the first request of a line
  assign eff_mate = line_open ? lat_mate : mate;
  assign eff_qual = line_open ? lat_qual : is_quality;
  assign eff_rev  = line_open ? lat_rev  : reversed;

  assign c_in  = eff_qual ? norm_quality(ch, qoff) : ch;
  assign c_rep = lat_qual ? buf_rd_data : complement(buf_rd_data);

  assign store_wr = in_acc && has_char && eff_rev && (line_len < STORE_MAX);
  assign ov_set   = in_acc && has_char && eff_rev && (line_len >= STORE_MAX);

  assign rep_cnt_m1 = rep_cnt - LEN_W'(1);
  assign rep_issue  = (state == S_REPLAY) && (rep_cnt != '0);

  // line state restarts once the result is captured
  always_comb begin
    len_next = line_len;
    if (line_done) begin
      len_next = '0;
    end else if (in_acc && has_char) begin
      if (eff_rev) begin
        if (line_len < STORE_MAX) begin
          len_next = line_len + LEN_W'(1);
        end
      end else if (line_len != LEN_MAX) begin
        len_next = line_len + LEN_W'(1);
      end
    end
  end

  always_comb begin
    hash_next = hash;
    if (line_done) begin
      hash_next = FNV_BASIS;
    end else if (in_acc && has_char && !eff_rev) begin
      hash_next = fnv_byte(hash, c_in);
    end else if (rep_pend) begin
      hash_next = fnv_byte(hash, c_rep);
    end
  end

  rlfnv_line_buf #(
    .MAX_LINE (MAX_LINE)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (line_len[AW-1:0]),
    .wr_data (c_in),
    .rd_en   (rep_issue),
    .rd_addr (rep_cnt_m1[AW-1:0]),
    .rd_data (buf_rd_data)
  );

  assign sreq.start = (state == S_STATS) && slot_free;
  assign sreq.mate  = lat_mate;
  assign sreq.qual  = lat_qual;
  assign sreq.hash  = hash;
  assign sreq.len   = line_len;

  rlfnv_stats u_stats (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .res (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      qoff <= '0;
    end else if (cfg_valid && cfg_ready) begin
      qoff <= quality_offset;
    end
  end

  // control FSM, line state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      hash      <= FNV_BASIS;
      line_len  <= '0;
      ov        <= 1'b0;
      line_open <= 1'b0;
      lat_mate  <= 1'b0;
      lat_qual  <= 1'b0;
      lat_rev   <= 1'b0;
      rep_cnt   <= '0;
      rep_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      hash     <= hash_next;
      line_len <= len_next;
      rep_pend <= rep_issue;
      if (ov_set) begin
        ov <= 1'b1;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IN: begin
          if (in_acc && (has_char || last)) begin
            line_open <= 1'b1;
            lat_mate  <= eff_mate;
            lat_qual  <= eff_qual;
            lat_rev   <= eff_rev;
            if (last) begin
              rep_cnt <= len_next;
              state   <= eff_rev ? S_REPLAY : S_STATS;
            end
          end
        end
        S_REPLAY: begin
          if (rep_cnt != '0) begin
            rep_cnt <= rep_cnt_m1;
          end else if (!rep_pend) begin
            state <= S_STATS;
          end
        end
        S_STATS: begin
          if (slot_free) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (sres.done) begin
            out_valid      <= 1'b1;
            line_hash      <= hash;
            out_mate       <= lat_mate;
            out_is_quality <= lat_qual;
            checksum       <= sres.checksum;
            row_count      <= sres.rows;
            base_count     <= sres.bases;
            overflow       <= ov;
            ov             <= 1'b0;
            line_open      <= 1'b0;
            state          <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

endmodule

`default_nettype wire
